[src/hex_sample_page_decoder_assert.svh]
// assertion macros for the page decoder
`ifndef HEX_SAMPLE_PAGE_DECODER_ASSERT_SVH
`define HEX_SAMPLE_PAGE_DECODER_ASSERT_SVH
`ifndef SYNTH
`define HSPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HSPD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/hspd_pkg.sv]
`timescale 1ns / 1ps
package hspd_pkg;
    typedef enum logic [1:0] {
        ST_TAKE,
        ST_CALC,
        ST_DIV,
        ST_OUT
    } t_state;

    localparam logic [2:0] REG_GAIN_X      = 3'd0;
    localparam logic [2:0] REG_GAIN_Y      = 3'd1;
    localparam logic [2:0] REG_GAIN_Z      = 3'd2;
    localparam logic [2:0] REG_OFFSET_X    = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y    = 3'd4;
    localparam logic [2:0] REG_OFFSET_Z    = 3'd5;
    localparam logic [2:0] REG_LIGHT_SCALE = 3'd6;

    localparam logic [1:0] CH_LIGHT = 2'd3;

    typedef struct packed {
        logic take;    // accept a character
        logic calc;    // value complete: set up scaling
        logic step;    // one divider step
        logic fin;     // form result
        logic done;    // result taken
    } t_cmd;

    typedef struct packed {
        logic complete;  // this character finishes a value
        logic div_busy;  // divider still iterating
    } t_status;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b0, c[3:0] + 4'd9};
        return r;
    endfunction
endpackage

[src/hspd_ctrl.sv]
`timescale 1ns / 1ps
module hspd_ctrl
    import hspd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_TAKE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_TAKE: if (i_valid && i_status.complete) n_state = ST_CALC;
            ST_CALC: n_state = ST_DIV;
            ST_DIV:  if (!i_status.div_busy) n_state = ST_OUT;
            ST_OUT:  if (i_out_ready) n_state = ST_TAKE;
            default: n_state = ST_TAKE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_TAKE: begin
                o_ready = 1'b1;
                o_cmd.take = i_valid;
            end
            ST_CALC: o_cmd.calc = 1'b1;
            ST_DIV: begin
                o_cmd.step = i_status.div_busy;
                o_cmd.fin = !i_status.div_busy;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.done = i_out_ready;
            end
            default: ;
        endcase
    end
endmodule

[src/hspd_datapath.sv]
`timescale 1ns / 1ps
module hspd_datapath
    import hspd_pkg::*;
#(
    parameter int SAMPLES_PER_PAGE = 300,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [7:0]         i_text_char,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output t_status            o_status,
    output logic [1:0]         o_channel,
    output logic signed [12:0] o_raw_value,
    output logic signed [42:0] o_scaled_value,
    output logic [8:0]         o_sample_index,
    output logic               o_last_of_sample,
    output logic               o_last_of_page,
    output logic               o_bad_digit,
    output logic               o_zero_gain
);
    // dividend magnitude below 2^22, shifted by FRAC_BITS
    localparam int NW = 22 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam int QW = (NW > 43) ? NW : 43;
    // light product rescaled from Q16.16 to FRAC_BITS fraction bits
    localparam int LSH_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int LSH_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int LW = 43 + LSH_UP;
    localparam logic [42:0] SMAX = {1'b0, {42{1'b1}}};

    logic [15:0] r_gain [3];
    logic [20:0] r_off [3];
    logic [31:0] r_light;
    logic [1:0]  r_digits;
    logic [11:0] r_accum;
    logic        r_stop;
    logic [1:0]  r_chan;
    logic [8:0]  r_sample;

    logic [11:0] r_val;
    logic        r_bad;
    logic        r_neg;
    logic        r_zg;
    logic [NW-1:0] r_quo;
    logic [15:0]   r_rem;
    logic [15:0]   r_div;
    logic [CW-1:0] r_cnt;
    logic [41:0]   r_lprod;
    logic signed [42:0] r_scaled;

    logic [4:0]  w_d;
    logic [11:0] w_acc;
    logic        w_stop;
    logic signed [21:0] w_num;
    logic [21:0] w_mag;
    logic [16:0] w_trial;
    logic [16:0] w_sub;
    logic [QW-1:0] w_q;
    logic [LW-1:0] w_light;

    assign w_d = hex_digit(i_text_char);
    assign w_stop = r_stop || w_d[4];
    assign w_acc = w_stop ? r_accum : {r_accum[7:0], w_d[3:0]};
    assign o_status.complete = (r_digits == 2'd2);
    assign o_status.div_busy = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= 16'd1; r_gain[1] <= 16'd1; r_gain[2] <= 16'd1;
            r_off[0] <= '0; r_off[1] <= '0; r_off[2] <= '0;
            r_light <= 32'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GAIN_X:      r_gain[0] <= i_cfg_data[15:0];
                REG_GAIN_Y:      r_gain[1] <= i_cfg_data[15:0];
                REG_GAIN_Z:      r_gain[2] <= i_cfg_data[15:0];
                REG_OFFSET_X:    r_off[0] <= i_cfg_data[20:0];
                REG_OFFSET_Y:    r_off[1] <= i_cfg_data[20:0];
                REG_OFFSET_Z:    r_off[2] <= i_cfg_data[20:0];
                REG_LIGHT_SCALE: r_light <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= '0; r_accum <= '0; r_stop <= 1'b0;
            r_chan <= '0; r_sample <= '0;
        end else if (i_cmd.take) begin
            if (r_digits == 2'd2) begin
                r_digits <= '0; r_accum <= '0; r_stop <= 1'b0;
                if (r_chan == CH_LIGHT) begin
                    r_chan <= '0;
                    if (r_sample >= 9'(SAMPLES_PER_PAGE - 1)) r_sample <= '0;
                    else r_sample <= r_sample + 9'd1;
                end else begin
                    r_chan <= r_chan + 2'd1;
                end
            end else begin
                r_digits <= r_digits + 2'd1;
                r_accum <= w_acc;
                r_stop <= w_stop;
            end
        end
    end

    // output-side fields latched when the value completes
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && r_digits == 2'd2) begin
            r_val <= w_acc;
            r_bad <= w_stop;
            o_channel <= r_chan;
            o_sample_index <= r_sample;
            o_last_of_sample <= (r_chan == CH_LIGHT);
            o_last_of_page <= (r_chan == CH_LIGHT) &&
                              (r_sample == 9'(SAMPLES_PER_PAGE - 1));
        end
    end

    assign w_num = 22'(signed'(r_val) * 22'sd100) - 22'(signed'(r_off[o_channel]));
    assign w_mag = w_num[21] ? 22'(-w_num) : 22'(w_num);
    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_sub = w_trial - {1'b0, r_div};
    assign w_q = QW'(r_quo);
    assign w_light = (LW'(r_lprod) << LSH_UP) >> LSH_DN;

    // restoring divider, one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.calc) begin
            r_neg <= w_num[21];
            r_quo <= NW'({w_mag, {FRAC_BITS{1'b0}}});
            r_rem <= '0;
            r_div <= r_gain[o_channel];
            r_zg <= (o_channel != CH_LIGHT) && (r_gain[o_channel] == '0);
            r_lprod <= 42'(r_val[11:2]) * 42'(r_light);
            r_cnt <= (o_channel != CH_LIGHT && r_gain[o_channel] != '0) ?
                     CW'(NW) : '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - CW'(1);
            if (!w_sub[16]) begin
                r_rem <= w_sub[15:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[15:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            if (o_channel == CH_LIGHT) begin
                if (w_light > LW'(SMAX)) r_scaled <= signed'(SMAX);
                else r_scaled <= signed'(w_light[42:0]);
            end else if (r_zg) begin
                r_scaled <= '0;
            end else if (w_q > QW'(SMAX)) begin
                r_scaled <= r_neg ? signed'(~SMAX) : signed'(SMAX);
            end else begin
                r_scaled <= r_neg ? signed'(-w_q[42:0]) : signed'(w_q[42:0]);
            end
        end
    end

    assign o_raw_value = (o_channel == CH_LIGHT) ? signed'({1'b0, r_val})
                                                 : signed'({r_val[11], r_val});
    assign o_scaled_value = r_scaled;
    assign o_bad_digit = r_bad;
    assign o_zero_gain = r_zg;
endmodule

[src/hex_sample_page_decoder.sv]
`timescale 1ns / 1ps
// Decodes a sensor page string one character per beat: every three hex
// characters give one value, cycling x, y, z acceleration and light. A
// character that completes no value is only accumulated. A completing
// character goes through a setup state and then, for acceleration, the
// bit-serial restoring divider (light and zero gain skip it), a step
// that forms the result, and then the result waits in the output
// register until taken. Configuration may be written any time the block
// is idle; writes to indexes beyond the register list are ignored.
module hex_sample_page_decoder
    import hspd_pkg::*;
#(
    parameter int SAMPLES_PER_PAGE = 300,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_text_char,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_channel,
    output logic signed [12:0] o_raw_value,
    output logic signed [42:0] o_scaled_value,
    output logic [8:0]         o_sample_index,
    output logic               o_last_of_sample,
    output logic               o_last_of_page,
    output logic               o_bad_digit,
    output logic               o_zero_gain,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
`include "hex_sample_page_decoder_assert.svh"
    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    hspd_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_out_ready(i_ready), .i_status(w_status),
        .o_ready, .o_out_valid(o_valid), .o_cmd(w_cmd)
    );

    hspd_datapath #(.SAMPLES_PER_PAGE(SAMPLES_PER_PAGE), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_text_char, .i_cfg_valid,
        .i_cfg_index, .i_cfg_data, .o_status(w_status), .o_channel, .o_raw_value,
        .o_scaled_value, .o_sample_index, .o_last_of_sample, .o_last_of_page,
        .o_bad_digit, .o_zero_gain
    );

    `HSPD_ASSERT_IMPL(a_no_take_while_out, i_clk, i_rst_n, o_valid, !o_ready)
    `HSPD_ASSERT_IMPL(a_page_end_is_light, i_clk, i_rst_n, o_valid && o_last_of_page, o_last_of_sample)
    `HSPD_ASSERT_IMPL(a_light_no_zg, i_clk, i_rst_n, o_valid && o_last_of_sample, !o_zero_gain)
    `HSPD_ASSERT_NEXT(a_out_after_take, i_clk, i_rst_n, o_valid && i_ready, o_ready && !o_valid)
endmodule
